FILE: hdl/binary_dual_build_line_word_top_assert.svh
// assertion macros for the binary dual line-word rebuild block
// relies on clk and rst_n being visible in the including module
`ifndef BINARY_DUAL_BUILD_LINE_WORD_TOP_ASSERT_SVH
`define BINARY_DUAL_BUILD_LINE_WORD_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define BDBL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define BDBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bdbl_pkg.sv
// shared constants, mode codes and lane/control structs for the line-word rebuild block
// no dependencies
package bdbl_pkg;

    // word and lane geometry
    localparam int WORD_BITS  = 64;
    localparam int LANE_BITS  = 8;
    localparam int LANES      = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
    localparam int PAD_BITS   = LANES * LANE_BITS;
    localparam int LANE_IDX_W = $clog2(LANE_BITS);
    localparam int LANE_CNT_W = $clog2(LANE_BITS + 1);
    localparam int CNT_W      = $clog2(WORD_BITS + 1);

    // fixed field widths on the ports
    localparam int FIELD_W = 64;
    localparam int VOL_W   = 48;
    localparam int MODE_W  = 3;

    // bits of the padded word that hold real pixels
    localparam logic [PAD_BITS-1:0] REAL_MASK = PAD_BITS'({WORD_BITS{1'b1}});

    // mode codes
    localparam logic [MODE_W-1:0] MODE_PLAIN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EDGE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SHIFT_L = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHIFT_R = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HORIZ_L = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HORIZ_R = 3'd5;

    // what a lane has to compute for one word
    typedef struct packed {
        logic fill;   // neighbour term is the edge fill
        logic shift;  // neighbour term comes from the adjacent pixel of the neighbour line
        logic chain;  // neighbour term comes from the adjacent rebuilt pixel
        logic left;   // chain runs from the top bit down
    } lane_op_t;

    // lane answers for both values of the incoming boundary bit
    typedef struct packed {
        logic [LANE_BITS-1:0]  word0;
        logic [LANE_BITS-1:0]  word1;
        logic [LANE_CNT_W-1:0] cnt0;
        logic [LANE_CNT_W-1:0] cnt1;
        logic                  cout0;
        logic                  cout1;
    } lane_res_t;

    // per-request control carried from the lane stage into the merge stage
    typedef struct packed {
        logic shift;
        logic chain;
        logic left;
        logic line_start;
        logic image_start;
        logic nbr_lo;
        logic nbr_hi;
    } step_ctrl_t;

endpackage

FILE: hdl/binary_dual_build_line_word_top.sv
// top level of the binary dual line-word rebuild block: handshake, lane stage, merge stage
// depends on bdbl_pkg, bdbl_lane, bdbl_merge and the assertion header
//
//   channel  direction  signals                         request
//   s_       in         tvalid tready tdata tuser       one germ/neighbour/mask word
//   m_       out        tvalid tready tdata             rebuilt word and running volume
//   cfg_     in         we wdata                        edge fill register
//
// one request per cycle while m_tready holds; results pass the lane and merge registers
// the rate is set by the merge stage, which owns the line carry and volume
// reset clears the valid flags, the volume and sets the edge fill and carry to ones
// a stalled output holds the lane stage, and the input stalls only once both stages are full
`include "binary_dual_build_line_word_top_assert.svh"

module binary_dual_build_line_word_top
    import bdbl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // germ_word, neighbour_word, mask_word
    input  logic [4:0]   s_tuser,   // mode, line_start, image_start
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata    // result_word, volume_total
);

    logic                  edge_filled_reg;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    lane_res_t [LANES-1:0] s1_res_reg;
    step_ctrl_t            s1_ctrl_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic                  out_free;
    logic                  s1_adv;
    logic                  s_acc;
    logic [MODE_W-1:0]     mode;
    lane_op_t              op;
    step_ctrl_t            ctrl_in;
    logic [PAD_BITS-1:0]   germ_pad;
    logic [PAD_BITS-1:0]   nbr_pad;
    logic [PAD_BITS-1:0]   mask_pad;
    logic [PAD_BITS-1:0]   pad_bits;
    lane_res_t [LANES-1:0] lane_res;
    logic [WORD_BITS-1:0]  result_word;
    logic [VOL_W-1:0]      volume_total;

    // edge fill register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_filled_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            edge_filled_reg <= cfg_wdata;
        end
    end

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;

    // mode decode
    assign mode = s_tuser[MODE_W-1:0];

    always_comb
    begin
        op = '0;
        case (mode)
            MODE_EDGE:    op.fill  = 1'b1;
            MODE_SHIFT_L: begin op.shift = 1'b1; op.left = 1'b1; end
            MODE_SHIFT_R: op.shift = 1'b1;
            MODE_HORIZ_L: begin op.chain = 1'b1; op.left = 1'b1; end
            MODE_HORIZ_R: op.chain = 1'b1;
            default:      op = '0;
        endcase
    end

    // control carried to the merge stage
    always_comb
    begin
        ctrl_in.shift       = op.shift;
        ctrl_in.chain       = op.chain;
        ctrl_in.left        = op.left;
        ctrl_in.line_start  = s_tuser[MODE_W];
        ctrl_in.image_start = s_tuser[MODE_W+1];
        ctrl_in.nbr_lo      = s_tdata[FIELD_W];
        ctrl_in.nbr_hi      = s_tdata[FIELD_W+WORD_BITS-1];
    end

    // word fields padded out to whole lanes
    assign germ_pad = PAD_BITS'(s_tdata[WORD_BITS-1:0]);
    assign nbr_pad  = PAD_BITS'(s_tdata[FIELD_W +: WORD_BITS]);
    assign mask_pad = PAD_BITS'(s_tdata[2*FIELD_W +: WORD_BITS]);
    assign pad_bits = ~REAL_MASK;

    // lanes side by side
    for (genvar gi = 0; gi < LANES; gi++)
    begin : g_lane
        bdbl_lane u_lane (
            .op       (op),
            .edge_bit (edge_filled_reg),
            .germ     (germ_pad[gi*LANE_BITS +: LANE_BITS]),
            .nbr      (nbr_pad[gi*LANE_BITS +: LANE_BITS]),
            .mask     (mask_pad[gi*LANE_BITS +: LANE_BITS]),
            .pad      (pad_bits[gi*LANE_BITS +: LANE_BITS]),
            .res      (lane_res[gi])
        );
    end

    // stage valid flags
    always_comb
    begin
        s1_valid_next  = s_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // lane stage payload
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_res_reg  <= lane_res;
            s1_ctrl_reg <= ctrl_in;
        end
    end

    // merge stage
    bdbl_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (s1_adv),
        .edge_filled  (edge_filled_reg),
        .lane_res     (s1_res_reg),
        .ctrl         (s1_ctrl_reg),
        .result_word  (result_word),
        .volume_total (volume_total)
    );

    // output request
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {volume_total, FIELD_W'(result_word)};

    // checks
    `BDBL_ASSERT_SAME(a_full_stall, s1_valid_reg && out_valid_reg && !m_tready, !s_tready, "input accepted with both stages full")
    `BDBL_ASSERT_NEXT(a_vol_grows, s1_adv && !s1_ctrl_reg.image_start, volume_total >= $past(volume_total), "volume decreased without image start")
    `BDBL_ASSERT_NEXT(a_vol_restart, s1_adv && s1_ctrl_reg.image_start, volume_total <= VOL_W'(WORD_BITS), "volume after image start exceeds one word")

endmodule

FILE: hdl/bdbl_lane.sv
// one lane: rebuilds a slice of the word for both values of the incoming boundary bit
// depends on bdbl_pkg
module bdbl_lane
    import bdbl_pkg::*;
(
    input  lane_op_t             op,
    input  logic                 edge_bit,
    input  logic [LANE_BITS-1:0] germ,
    input  logic [LANE_BITS-1:0] nbr,
    input  logic [LANE_BITS-1:0] mask,
    input  logic [LANE_BITS-1:0] pad,
    output lane_res_t            res
);

    typedef struct packed {
        logic [LANE_BITS-1:0]  word;
        logic [LANE_CNT_W-1:0] cnt;
        logic                  cout;
    } lane_pass_t;

    // walk the slice in chain order; padding bits let the boundary bit straight through
    function automatic lane_pass_t run_pass(
        input lane_op_t             op_in,
        input logic                 edge_in,
        input logic [LANE_BITS-1:0] g,
        input logic [LANE_BITS-1:0] n,
        input logic [LANE_BITS-1:0] m,
        input logic [LANE_BITS-1:0] pd,
        input logic                 cin
    );
        lane_pass_t             r;
        logic                   x;
        logic                   o;
        logic [LANE_IDX_W-1:0]  idx;
        r.word = '0;
        r.cnt  = '0;
        x      = cin;
        for (int k = 0; k < LANE_BITS; k++)
        begin
            idx = op_in.left ? LANE_IDX_W'(LANE_BITS - 1 - k) : LANE_IDX_W'(k);
            if (pd[idx])
            begin
                o = 1'b0;
            end
            else
            begin
                if (op_in.shift || op_in.chain)
                begin
                    o = (g[idx] & x) | m[idx];
                end
                else
                begin
                    o = (g[idx] & (op_in.fill ? edge_in : n[idx])) | m[idx];
                end
                // a germ run stays alive up to and including the next mask pixel
                x = op_in.chain ? (g[idx] & (m[idx] | x)) : n[idx];
            end
            r.word[idx] = o;
            r.cnt       = r.cnt + LANE_CNT_W'(o);
        end
        r.cout = x;
        return r;
    endfunction

    lane_pass_t pass0;
    lane_pass_t pass1;

    // both boundary hypotheses side by side
    always_comb
    begin
        pass0 = run_pass(op, edge_bit, germ, nbr, mask, pad, 1'b0);
        pass1 = run_pass(op, edge_bit, germ, nbr, mask, pad, 1'b1);
    end

    // pack the answers for the merge stage
    always_comb
    begin
        res.word0 = pass0.word;
        res.word1 = pass1.word;
        res.cnt0  = pass0.cnt;
        res.cnt1  = pass1.cnt;
        res.cout0 = pass0.cout;
        res.cout1 = pass1.cout;
    end

endmodule

FILE: hdl/bdbl_merge.sv
// merge stage: resolves the boundary chain across lanes, sums the counts,
// holds the line carry bits, the volume and the result register; depends on bdbl_pkg
module bdbl_merge
    import bdbl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  edge_filled,
    input  lane_res_t [LANES-1:0] lane_res,
    input  step_ctrl_t            ctrl,
    output logic [WORD_BITS-1:0]  result_word,
    output logic [VOL_W-1:0]      volume_total
);

    logic                 carry_lo_reg;
    logic                 carry_lo_next;
    logic                 carry_hi_reg;
    logic                 carry_hi_next;
    logic [VOL_W-1:0]     volume_reg;
    logic [VOL_W-1:0]     volume_next;
    logic [WORD_BITS-1:0] result_reg;

    logic                 cin;
    logic                 link;
    logic [PAD_BITS-1:0]  word_pad;
    logic [CNT_W-1:0]     cnt_total;
    logic [WORD_BITS-1:0] word;
    logic [VOL_W:0]       vol_sum;
    logic [VOL_W-1:0]     vol_base;

    // boundary bit entering the first lane of the chain
    assign cin = ctrl.line_start ? edge_filled : (ctrl.left ? carry_lo_reg : carry_hi_reg);

    // pick each lane's answer in chain order and add up its ones
    always_comb
    begin
        int li;
        link      = cin;
        word_pad  = '0;
        cnt_total = '0;
        for (int k = 0; k < LANES; k++)
        begin
            li = ctrl.left ? (LANES - 1 - k) : k;
            word_pad[li*LANE_BITS +: LANE_BITS] = link ? lane_res[li].word1
                                                       : lane_res[li].word0;
            cnt_total = cnt_total + CNT_W'(link ? lane_res[li].cnt1 : lane_res[li].cnt0);
            link      = link ? lane_res[li].cout1 : lane_res[li].cout0;
        end
    end

    assign word = word_pad[WORD_BITS-1:0];

    // saturating volume update
    always_comb
    begin
        vol_base    = ctrl.image_start ? '0 : volume_reg;
        vol_sum     = {1'b0, vol_base} + (VOL_W + 1)'(cnt_total);
        volume_next = vol_sum[VOL_W] ? {VOL_W{1'b1}} : vol_sum[VOL_W-1:0];
    end

    // carry bits for the next word of the line
    always_comb
    begin
        carry_lo_next = carry_lo_reg;
        carry_hi_next = carry_hi_reg;
        if (ctrl.shift)
        begin
            carry_lo_next = ctrl.nbr_lo;
            carry_hi_next = ctrl.nbr_hi;
        end
        else if (ctrl.chain)
        begin
            carry_lo_next = word[0];
            carry_hi_next = word[WORD_BITS-1];
        end
        else if (ctrl.line_start)
        begin
            carry_lo_next = edge_filled;
            carry_hi_next = edge_filled;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_lo_reg <= 1'b1;
            carry_hi_reg <= 1'b1;
            volume_reg   <= '0;
        end
        else if (load)
        begin
            carry_lo_reg <= carry_lo_next;
            carry_hi_reg <= carry_hi_next;
            volume_reg   <= volume_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= word;
        end
    end

    assign result_word  = result_reg;
    assign volume_total = volume_reg;

endmodule

FILE: sim/tb.sv
// self-checking bench for binary_dual_build_line_word_top: streamed word requests, own rebuild predictor
// depends on bdbl_pkg and the rtl of the block under test
module tb;
    import bdbl_pkg::*;

    // spare mode codes, which the block treats as plain
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
    localparam logic [VOL_W-1:0]  VOL_LIMIT    = '1;
    localparam int                PHASES       = 5;
    localparam int                PHASE_ITEMS  = 250;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [FIELD_W-1:0] germ;
        logic [FIELD_W-1:0] nbr;
        logic [FIELD_W-1:0] mask;
        logic               line_start;
        logic               image_start;
    } word_req_t;

    typedef struct {
        logic [FIELD_W-1:0] word;
        logic [VOL_W-1:0]   volume;
    } rebuilt_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;   // germ_word, neighbour_word, mask_word
    logic [4:0]   s_tuser;   // mode, line_start, image_start
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;   // result_word, volume_total

    word_req_t pending_q[$];
    rebuilt_t  rebuilt_q[$];

    // predictor state
    logic [FIELD_W-1:0] line_carry;
    logic [VOL_W-1:0]   pixel_volume;
    logic               edge_fill;

    logic      in_taken;
    int        gap_pct;
    int        fault_count;
    word_req_t next_req;
    word_req_t seen_req;
    rebuilt_t  want;

    binary_dual_build_line_word_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // expected rebuilt word and volume for one accepted request
    function automatic void rebuild_step(input word_req_t rq);
        logic [FIELD_W-1:0] fill;
        logic [FIELD_W-1:0] v;
        logic [VOL_W:0]     sum;
        rebuilt_t           r;
        fill = edge_fill ? '1 : '0;
        if (rq.line_start)
            line_carry = fill;
        if (rq.image_start)
            pixel_volume = '0;
        case (rq.mode)
            MODE_EDGE:
                r.word = (rq.germ & fill) | rq.mask;
            MODE_SHIFT_L:
            begin
                r.word = (rq.germ & ((rq.nbr >> 1) | (line_carry << (WORD_BITS - 1)))) | rq.mask;
                line_carry = rq.nbr;
            end
            MODE_SHIFT_R:
            begin
                r.word = (rq.germ & ((rq.nbr << 1) | (line_carry >> (WORD_BITS - 1)))) | rq.mask;
                line_carry = rq.nbr;
            end
            MODE_HORIZ_L:
            begin
                v = rq.germ;
                for (int i = 0; i < WORD_BITS; i++)
                    v = (v & ((v >> 1) | (line_carry << (WORD_BITS - 1)))) | rq.mask;
                r.word = v;
                line_carry = v;
            end
            MODE_HORIZ_R:
            begin
                v = rq.germ;
                for (int i = 0; i < WORD_BITS; i++)
                    v = (v & ((v << 1) | (line_carry >> (WORD_BITS - 1)))) | rq.mask;
                r.word = v;
                line_carry = v;
            end
            default:
                r.word = (rq.germ & rq.nbr) | rq.mask;
        endcase
        sum = {1'b0, pixel_volume} + (VOL_W + 1)'($countones(r.word));
        pixel_volume = (sum > {1'b0, VOL_LIMIT}) ? VOL_LIMIT : sum[VOL_W-1:0];
        r.volume = pixel_volume;
        rebuilt_q.push_back(r);
    endfunction

    // random word with a mix of densities so that runs and gaps both occur
    function automatic logic [FIELD_W-1:0] pixel_word();
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return a | b | c;
            3: return a & b & c;
            4: return ~(a & b & c) ;
            5: return {FIELD_W{1'b1}} >> $urandom_range(WORD_BITS - 1);
            default: return a;
        endcase
    endfunction

    task automatic add_req(input logic [MODE_W-1:0] mode, input logic [FIELD_W-1:0] germ,
                           input logic [FIELD_W-1:0] nbr, input logic [FIELD_W-1:0] mask,
                           input logic ls, input logic is);
        word_req_t rq;
        rq.mode        = mode;
        rq.germ        = germ;
        rq.nbr         = nbr;
        rq.mask        = mask;
        rq.line_start  = ls;
        rq.image_start = is;
        pending_q.push_back(rq);
    endtask

    // mostly whole lines of one direction, with some loose noise requests
    task automatic add_random_lines(input int n_items);
        int                count;
        int                len;
        logic [MODE_W-1:0] m_a;
        logic [MODE_W-1:0] m_b;
        logic [MODE_W-1:0] mode;
        count = 0;
        while (count < n_items)
        begin
            if ($urandom_range(99) < 15)
            begin
                add_req(MODE_W'($urandom_range(7)), pixel_word(), pixel_word(), pixel_word(),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
                count++;
            end
            else
            begin
                case ($urandom_range(5))
                    0: begin m_a = MODE_SHIFT_L; m_b = MODE_HORIZ_L; end
                    1: begin m_a = MODE_SHIFT_R; m_b = MODE_HORIZ_R; end
                    2: begin m_a = MODE_HORIZ_L; m_b = MODE_HORIZ_L; end
                    3: begin m_a = MODE_HORIZ_R; m_b = MODE_HORIZ_R; end
                    4: begin m_a = MODE_PLAIN;   m_b = MODE_EDGE;    end
                    default: begin m_a = MODE_SHIFT_L; m_b = MODE_SHIFT_R; end
                endcase
                len = $urandom_range(8, 1);
                for (int i = 0; i < len; i++)
                begin
                    mode = $urandom_range(1) ? m_a : m_b;
                    add_req(mode, pixel_word(), pixel_word(), pixel_word(), i == 0,
                            (i == 0) && ($urandom_range(9) == 0));
                    count++;
                end
            end
        end
    endtask

    // block idle: nothing queued, nothing presented, nothing outstanding, seen twice in a row
    task automatic wait_drained();
        int quiet;
        quiet = 0;
        while (quiet < 2)
        begin
            @(negedge clk);
            if (pending_q.size() == 0 && !s_tvalid && rebuilt_q.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic write_edge_fill(input logic value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        edge_fill = value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    next_req = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_req.mask, next_req.nbr, next_req.germ};
                    s_tuser  <= {next_req.image_start, next_req.line_start, next_req.mode};
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= gap_pct);
        end
    end

    // monitor: check results in order, predict each accepted request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (rebuilt_q.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual %h",
                             $time, m_tdata);
                    fault_count++;
                end
                else
                begin
                    want = rebuilt_q.pop_front();
                    if (m_tdata[63:0] !== want.word)
                    begin
                        $display("%0t result_word: expected %h actual %h",
                                 $time, want.word, m_tdata[63:0]);
                        fault_count++;
                    end
                    if (m_tdata[111:64] !== want.volume)
                    begin
                        $display("%0t volume_total: expected %h actual %h",
                                 $time, want.volume, m_tdata[111:64]);
                        fault_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                seen_req.germ        = s_tdata[63:0];
                seen_req.nbr         = s_tdata[127:64];
                seen_req.mask        = s_tdata[191:128];
                seen_req.mode        = s_tuser[2:0];
                seen_req.line_start  = s_tuser[3];
                seen_req.image_start = s_tuser[4];
                rebuild_step(seen_req);
            end
        end
    end

    // reset, directed checks, then random lines across register settings
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        in_taken     = 1'b0;
        gap_pct      = 14;
        fault_count  = 0;
        edge_fill    = 1'b1;
        line_carry   = '1;
        pixel_volume = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill of ones: every mode, field extremes, carry into a line start
        write_edge_fill(1'b1);
        add_req(MODE_SHIFT_R, '1, '0, '0, 1'b0, 1'b1);
        add_req(MODE_PLAIN, '1, '1, '0, 1'b1, 1'b1);
        add_req(MODE_PLAIN, '1, '0, '0, 1'b0, 1'b0);
        add_req(MODE_PLAIN, '0, '0, '1, 1'b0, 1'b0);
        add_req(MODE_EDGE, '1, '0, '0, 1'b0, 1'b0);
        add_req(MODE_EDGE, {32{2'b10}}, '1, {32{2'b01}}, 1'b0, 1'b0);
        add_req(MODE_SHIFT_R, '1, 64'h8000_0000_0000_0000, '0, 1'b1, 1'b0);
        add_req(MODE_SHIFT_R, '1, '0, '0, 1'b0, 1'b0);
        add_req(MODE_SHIFT_L, '1, 64'h1, '0, 1'b1, 1'b0);
        add_req(MODE_SHIFT_L, '1, '1, '0, 1'b0, 1'b0);
        add_req(MODE_HORIZ_L, '1, '0, '0, 1'b1, 1'b0);
        add_req(MODE_HORIZ_L, 64'hFFFF_0000_FFFF_FFFF, '0, 64'h0000_0100_0000_0000, 1'b0, 1'b0);
        add_req(MODE_HORIZ_R, {4{16'h00FF}}, '1, 64'h1, 1'b1, 1'b0);
        add_req(MODE_HORIZ_R, '1, '0, '0, 1'b0, 1'b0);
        add_req(MODE_SPARE_6, 64'hDEAD_BEEF_0123_4567, 64'hFFFF_0000_FFFF_0000, 64'h10, 1'b0, 1'b0);
        add_req(MODE_SPARE_7, '1, 64'h0F0F_0F0F_0F0F_0F0F, '0, 1'b1, 1'b1);
        add_req(MODE_SHIFT_R, '1, '1, '0, 1'b0, 1'b0);
        wait_drained();

        // fill of zeros: carry kept over the register change, then reloaded
        write_edge_fill(1'b0);
        add_req(MODE_SHIFT_L, '1, '0, '0, 1'b0, 1'b0);
        add_req(MODE_EDGE, '1, '1, '0, 1'b0, 1'b0);
        add_req(MODE_HORIZ_L, '1, '1, '0, 1'b1, 1'b0);
        add_req(MODE_HORIZ_R, '1, '0, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
        add_req(MODE_PLAIN, '1, '1, '1, 1'b1, 1'b1);
        add_req(MODE_SHIFT_R, '1, '1, '0, 1'b0, 1'b0);
        wait_drained();

        // random lines, one phase without any idling
        for (int p = 0; p < PHASES; p++)
        begin
            gap_pct = (p == 2) ? 0 : 14;
            write_edge_fill((p % 2) == 0);
            add_random_lines(PHASE_ITEMS);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (fault_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/bdbl_pkg.sv
hdl/bdbl_lane.sv
hdl/bdbl_merge.sv
hdl/binary_dual_build_line_word_top.sv
sim/tb.sv
